// File: sv/prisched_pkg.sv
// prisched_pkg: request/response payload types, request codes and fsm states
// for the priority scheduler block. no dependencies.
package prisched_pkg;

	// payload field widths fixed by the interface
	localparam int unsigned PRIO_IN_W  = 5;
	localparam int unsigned TICKS_W    = 16;
	localparam int unsigned PRIO_OUT_W = 6;
	localparam int unsigned MASK_W     = 32;

	// request codes
	typedef enum logic [1:0] {
		REQ_READY = 2'd0,
		REQ_DELAY = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_SCHED = 2'd3
	} req_kind_t;

	// request transaction payload
	typedef struct packed {
		req_kind_t            req_type;
		logic [PRIO_IN_W-1:0] task_prio;
		logic [TICKS_W-1:0]   delay_ticks;
	} sched_req_t;

	// response transaction payload
	typedef struct packed {
		logic [PRIO_OUT_W-1:0] next_prio;
		logic [PRIO_OUT_W-1:0] current_prio;
		logic                  switch_needed;
		logic [MASK_W-1:0]     ready_mask;
	} sched_rsp_t;

	// control states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_DONE
	} sched_state_t;

endpackage

// File: sv/priority_task_scheduler_with_delays_top.sv
// priority_task_scheduler_with_delays_top: ready bitmap scheduler with a
// delay counter memory and a two-entry response queue. uses prisched_pkg.

// Bitmap priority scheduler. One response per request. Make-ready, delay and
// schedule requests finish in the cycle they are accepted. A tick walks the
// delay counter memory (one read port, one write port) one entry per cycle,
// so the block takes no new request until the walk and its flush and done
// states are over. Lower numbers are more urgent; priority 0 is never marked
// ready; next_prio of MAX_TASKS means no task is ready. Counter entries carry
// valid bits cleared by reset, so no clearing pass is needed. A response may
// sit stalled at the output while the next request is accepted.
module priority_task_scheduler_with_delays_top #(
	parameter int unsigned MAX_TASKS  = 32,
	parameter int unsigned DELAY_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  prisched_pkg::sched_req_t req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output prisched_pkg::sched_rsp_t rsp
);

	localparam int unsigned IDX_W  = $clog2(MAX_TASKS);
	localparam int unsigned PRIO_W = $clog2(MAX_TASKS + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_TASKS - 1);
	localparam logic [PRIO_W-1:0] NO_PRIO  = PRIO_W'(MAX_TASKS);
	localparam logic [prisched_pkg::PRIO_IN_W:0] PRIO_IN_CMP =
		(prisched_pkg::PRIO_IN_W + 1)'(MAX_TASKS);

	// architectural state
	prisched_pkg::sched_state_t state_q, state_d;
	logic [MAX_TASKS-1:0] ready_q, ready_d;
	logic [PRIO_W-1:0]    running_q, running_d;
	logic [PRIO_W-1:0]    best_q, best_d;

	// delay counter memory and its valid bits
	logic [DELAY_BITS-1:0] cnt_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0]  cnt_vld_q;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic [DELAY_BITS-1:0] wr_data;

	// tick walk pipeline
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_cnt_q;
	logic                  tick_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [DELAY_BITS-1:0] cnt_rd_s1;
	logic                  cnt_vld_s1;
	logic [DELAY_BITS-1:0] cnt_cur;

	// request decode
	logic                  accept;
	logic                  prio_ok;
	logic                  run_ok;
	logic [DELAY_BITS-1:0] ticks_sat;
	logic [MAX_TASKS-1:0]  dly_mask;
	logic [MAX_TASKS-1:0]  pick_src;
	logic [PRIO_W-1:0]     pick;
	logic                  sw;

	// response queue
	logic                     res_en;
	prisched_pkg::sched_rsp_t res_d;
	prisched_pkg::sched_rsp_t out_q, skid_q;
	logic                     out_vld_q, skid_vld_q;
	logic                     take, out_load_new, out_load_skid, skid_load;

	assign req_stall = !(state_q == prisched_pkg::ST_IDLE && !skid_vld_q);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prisched_pkg::ST_IDLE: begin
				if (accept && req.req_type == prisched_pkg::REQ_TICK) begin
					state_d = prisched_pkg::ST_WALK;
				end
			end
			prisched_pkg::ST_WALK: begin
				if (rd_cnt_q == LAST_IDX) begin
					state_d = prisched_pkg::ST_FLUSH;
				end
			end
			prisched_pkg::ST_FLUSH: state_d = prisched_pkg::ST_DONE;
			prisched_pkg::ST_DONE:  state_d = prisched_pkg::ST_IDLE;
			default:                state_d = prisched_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		rd_en  = (state_q == prisched_pkg::ST_WALK);
		res_en = (state_q == prisched_pkg::ST_DONE) ||
			(accept && req.req_type != prisched_pkg::REQ_TICK);
	end

	// request qualifiers
	always_comb begin
		prio_ok = (req.task_prio != '0) &&
			({1'b0, req.task_prio} < PRIO_IN_CMP);
		run_ok = (running_q < NO_PRIO);
		if ((DELAY_BITS < prisched_pkg::TICKS_W) &&
				((req.delay_ticks >> DELAY_BITS) != '0)) begin
			ticks_sat = '1;
		end else begin
			ticks_sat = DELAY_BITS'(req.delay_ticks);
		end
		dly_mask = '0;
		if (req.req_type == prisched_pkg::REQ_DELAY && run_ok) begin
			dly_mask[running_q[IDX_W-1:0]] = 1'b1;
		end
		pick_src = ready_q & ~dly_mask;
	end

	// lowest-numbered ready priority
	always_comb begin
		pick = NO_PRIO;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (pick_src[i]) begin
				pick = PRIO_W'(i);
			end
		end
	end

	// counter value seen by the walk, unwritten entries read as zero
	assign cnt_cur = cnt_vld_s1 ? cnt_rd_s1 : '0;

	// state update and memory write
	always_comb begin
		ready_d   = ready_q;
		running_d = running_q;
		best_d    = best_q;
		sw        = 1'b0;
		wr_en     = 1'b0;
		wr_idx    = running_q[IDX_W-1:0];
		wr_data   = ticks_sat;
		if (accept) begin
			unique case (req.req_type)
				prisched_pkg::REQ_READY: begin
					if (prio_ok) begin
						ready_d[req.task_prio[IDX_W-1:0]] = 1'b1;
					end
				end
				prisched_pkg::REQ_DELAY: begin
					if (req.delay_ticks != '0) begin
						ready_d   = pick_src;
						wr_en     = run_ok;
						best_d    = pick;
						running_d = pick;
						sw        = (pick != running_q);
					end
				end
				prisched_pkg::REQ_TICK: begin
				end
				prisched_pkg::REQ_SCHED: begin
					best_d    = pick;
					running_d = pick;
					sw        = (pick != running_q);
				end
				default: begin
				end
			endcase
		end
		// tick write-back of the entry read last cycle
		if (tick_vld_s1 && cnt_cur != '0) begin
			wr_en   = 1'b1;
			wr_idx  = idx_s1;
			wr_data = cnt_cur - 1'b1;
			if (cnt_cur == DELAY_BITS'(1) && idx_s1 != '0) begin
				ready_d[idx_s1] = 1'b1;
			end
		end
	end

	// response built from the updated state
	always_comb begin
		res_d.next_prio     = prisched_pkg::PRIO_OUT_W'(best_d);
		res_d.current_prio  = prisched_pkg::PRIO_OUT_W'(running_d);
		res_d.switch_needed = sw;
		res_d.ready_mask    = prisched_pkg::MASK_W'(ready_d);
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prisched_pkg::ST_IDLE;
			ready_q     <= '0;
			running_q   <= '0;
			best_q      <= '0;
			cnt_vld_q   <= '0;
			rd_cnt_q    <= '0;
			tick_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			ready_q     <= ready_d;
			running_q   <= running_d;
			best_q      <= best_d;
			tick_vld_s1 <= rd_en;
			if (wr_en) begin
				cnt_vld_q[wr_idx] <= 1'b1;
			end
			if (state_q == prisched_pkg::ST_IDLE) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// counter memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			cnt_rd_s1  <= cnt_mem[rd_cnt_q];
			cnt_vld_s1 <= cnt_vld_q[rd_cnt_q];
			idx_s1     <= rd_cnt_q;
		end
	end

	// response queue steering
	always_comb begin
		take          = out_vld_q && !rsp_stall;
		out_load_skid = take && skid_vld_q;
		out_load_new  = res_en && (!out_vld_q || take) && !skid_vld_q;
		skid_load     = res_en && !out_load_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q  <= out_load_new || out_load_skid || (out_vld_q && !take);
			skid_vld_q <= skid_load || (skid_vld_q && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_skid) begin
			out_q <= skid_q;
		end else if (out_load_new) begin
			out_q <= res_d;
		end
		if (skid_load) begin
			skid_q <= res_d;
		end
	end

endmodule

// File: sv/prisched_checker.sv
// prisched_checker: port-level assertions for the priority scheduler top,
// bound to it below. uses prisched_pkg.
module prisched_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_stall,
	input prisched_pkg::sched_req_t req,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input prisched_pkg::sched_rsp_t rsp
);

	// a tick transaction keeps the block busy while the counters are walked
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.req_type == prisched_pkg::REQ_TICK
		|=> req_stall)
		else $error("request taken during tick walk");

	// a switch is only flagged together with the newly chosen priority
	a_switch_prio: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.switch_needed |-> rsp.current_prio == rsp.next_prio)
		else $error("switch flagged with mismatched priorities");

	// priority zero never shows as ready
	a_prio0_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !rsp.ready_mask[0])
		else $error("priority zero marked ready");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind priority_task_scheduler_with_delays_top prisched_checker u_prisched_checker (.*);

// File: sim/priority_task_scheduler_with_delays_top_test.sv
// priority_task_scheduler_with_delays_top_test: self-checking bench for the bitmap priority
// scheduler. directed table, then random traffic across idle/stall phases, scoreboard from
// an internal predictor. depends on prisched_pkg and priority_task_scheduler_with_delays_top.
`timescale 1ns / 1ps

module priority_task_scheduler_with_delays_top_test;

	localparam int unsigned NTASK          = 32;
	localparam int unsigned DBITS          = 16;
	localparam int unsigned RAND_PER_PHASE = 450;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned DRAIN_CYCLES   = 60;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned NDIR           = 25;

	// one directed row: request, whether the response is typed in, typed response
	typedef struct packed {
		prisched_pkg::sched_req_t stim;
		logic                     fixed;
		prisched_pkg::sched_rsp_t want;
	} dir_row_t;

	localparam prisched_pkg::sched_rsp_t ANY = '0;

	localparam dir_row_t DIRECTED [NDIR] = '{
		{prisched_pkg::REQ_READY, 5'd0,  16'd0,    1'b1, 6'd0,  6'd0,  1'b0, 32'h0},
		{prisched_pkg::REQ_DELAY, 5'd0,  16'd2,    1'b1, 6'd32, 6'd32, 1'b1, 32'h0},
		{prisched_pkg::REQ_TICK,  5'd31, 16'hFFFF, 1'b1, 6'd32, 6'd32, 1'b0, 32'h0},
		{prisched_pkg::REQ_TICK,  5'd0,  16'd0,    1'b1, 6'd32, 6'd32, 1'b0, 32'h0},
		{prisched_pkg::REQ_SCHED, 5'd0,  16'd0,    1'b1, 6'd32, 6'd32, 1'b0, 32'h0},
		{prisched_pkg::REQ_DELAY, 5'd0,  16'd5,    1'b1, 6'd32, 6'd32, 1'b0, 32'h0},
		{prisched_pkg::REQ_READY, 5'd31, 16'd0,    1'b1, 6'd32, 6'd32, 1'b0, 32'h8000_0000},
		{prisched_pkg::REQ_READY, 5'd1,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_DELAY, 5'd0,  16'd0,    1'b1, 6'd32, 6'd32, 1'b0, 32'h8000_0002},
		{prisched_pkg::REQ_SCHED, 5'd0,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_DELAY, 5'd0,  16'hFFFF, 1'b0, ANY},
		{prisched_pkg::REQ_SCHED, 5'd31, 16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_READY, 5'd5,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_READY, 5'd10, 16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_READY, 5'd21, 16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_SCHED, 5'd0,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_DELAY, 5'd0,  16'd1,    1'b0, ANY},
		{prisched_pkg::REQ_TICK,  5'd0,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_SCHED, 5'd0,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_DELAY, 5'd0,  16'h5555, 1'b0, ANY},
		{prisched_pkg::REQ_SCHED, 5'd0,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_DELAY, 5'd0,  16'hAAAA, 1'b0, ANY},
		{prisched_pkg::REQ_TICK,  5'd0,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_READY, 5'd0,  16'd0,    1'b0, ANY},
		{prisched_pkg::REQ_SCHED, 5'd0,  16'd0,    1'b0, ANY}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_stall;
	prisched_pkg::sched_req_t req;
	logic                     rsp_valid;
	logic                     rsp_stall;
	prisched_pkg::sched_rsp_t rsp;

	priority_task_scheduler_with_delays_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// predictor state: ready bitmap, delay counters, running and chosen priority
	logic [NTASK-1:0] rdy_map;
	logic [DBITS-1:0] wait_count [NTASK];
	logic [5:0]       run_prio;
	logic [5:0]       pick_prio;

	prisched_pkg::sched_rsp_t pending_rsp [$];
	prisched_pkg::sched_rsp_t rsp_want;
	int unsigned              mismatches = 0;
	int unsigned              idle_cycles = 0;
	int unsigned              send_idle_pct = 0;
	int unsigned              recv_stall_pct = 0;
	logic                     hold_off = 1'b0;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void set_ready(input int unsigned p);
		if (p != 0 && p < NTASK)
			rdy_map[p] = 1'b1;
	endfunction

	// lowest-numbered ready priority, NTASK when none; returns the switch flag
	function automatic logic pick_next();
		int unsigned p;
		logic        sw;
		p = 0;
		while (p < NTASK && !rdy_map[p])
			p++;
		pick_prio = 6'(p);
		sw = (pick_prio != run_prio);
		run_prio = pick_prio;
		return sw;
	endfunction

	// advance the scheduler state by one request and give its response
	function automatic prisched_pkg::sched_rsp_t predict_response(
		input prisched_pkg::sched_req_t r);
		logic                     sw;
		int                       i;
		prisched_pkg::sched_rsp_t o;
		sw = 1'b0;
		case (r.req_type)
			prisched_pkg::REQ_READY: set_ready(32'(r.task_prio));
			prisched_pkg::REQ_DELAY: begin
				// ticks field is exactly DBITS wide, so no saturation is reachable
				if (r.delay_ticks != 0) begin
					if (run_prio < NTASK) begin
						rdy_map[run_prio] = 1'b0;
						wait_count[run_prio] = r.delay_ticks;
					end
					sw = pick_next();
				end
			end
			prisched_pkg::REQ_TICK: begin
				for (i = 0; i < NTASK; i++) begin
					if (wait_count[i] != 0) begin
						wait_count[i] = wait_count[i] - 1'b1;
						if (wait_count[i] == 0)
							set_ready(i);
					end
				end
			end
			default: sw = pick_next();
		endcase
		o.next_prio     = pick_prio;
		o.current_prio  = run_prio;
		o.switch_needed = sw;
		o.ready_mask    = rdy_map;
		return o;
	endfunction

	// random request: mostly short delays so counters expire often
	function automatic prisched_pkg::sched_req_t random_request();
		prisched_pkg::sched_req_t r;
		int unsigned              kind;
		kind = $urandom_range(99);
		r.task_prio   = 5'($urandom_range(31));
		r.delay_ticks = 16'($urandom_range(65535));
		if (kind < 30) begin
			r.req_type = prisched_pkg::REQ_READY;
		end else if (kind < 50) begin
			r.req_type = prisched_pkg::REQ_DELAY;
			if ($urandom_range(99) < 80)
				r.delay_ticks = 16'($urandom_range(6));
		end else if (kind < 80) begin
			r.req_type = prisched_pkg::REQ_TICK;
		end else begin
			r.req_type = prisched_pkg::REQ_SCHED;
		end
		return r;
	endfunction

	// offer one transaction; called and returns at a falling edge
	task automatic send_item(input prisched_pkg::sched_req_t item,
		input prisched_pkg::sched_rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(want);
		@(negedge clk);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// stimulus
	initial begin
		int                       k;
		int unsigned              ph;
		prisched_pkg::sched_req_t item;
		prisched_pkg::sched_rsp_t want;
		rdy_map   = '0;
		run_prio  = '0;
		pick_prio = '0;
		for (k = 0; k < NTASK; k++)
			wait_count[k] = '0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (k = 0; k < NDIR; k++) begin
			want = predict_response(DIRECTED[k].stim);
			if (DIRECTED[k].fixed)
				want = DIRECTED[k].want;
			send_item(DIRECTED[k].stim, want);
		end

		// random phases: no idling, sender idle, receiver stall, both
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 27 : 0;
			recv_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 27 : 0;
			for (k = 0; k < RAND_PER_PHASE; k++) begin
				// long receiver hold-off while requests keep coming
				if (ph == 0 && k == 100)
					hold_off = 1'b1;
				item = random_request();
				want = predict_response(item);
				send_item(item, want);
			end
		end
		req_valid <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// receiver stall generation
	initial begin
		logic held;
		held      = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// response scoreboard
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected response: expected none actual %h", $time, rsp);
				mismatches++;
			end else begin
				rsp_want = pending_rsp.pop_front();
				check_field("next_prio", 32'(rsp_want.next_prio), 32'(rsp.next_prio));
				check_field("current_prio", 32'(rsp_want.current_prio),
					32'(rsp.current_prio));
				check_field("switch_needed", 32'(rsp_want.switch_needed),
					32'(rsp.switch_needed));
				check_field("ready_mask", rsp_want.ready_mask, rsp.ready_mask);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
